FILE: rtl/core/lobm_pkg.sv
// Shared types, constants and ranking functions for the order book matcher.
package lobm_pkg;

    localparam int BOOK_DEPTH = 32;
    localparam int ID_W       = 16;
    localparam int QTY_W      = 20;
    localparam int PRICE_W    = 24;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 80;

    // Input opcodes.
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Order sides.
    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_TRADE  = 2'd0,
        KIND_UNEXEC = 2'd1,
        KIND_REJECT = 2'd2
    } t_kind;

    // One resting order.
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [QTY_W-1:0]   qty;
        logic [PRICE_W-1:0] price;
        logic               mkt;
    } t_entry;

    // Operation applied to one side of the book in a cycle.
    typedef enum logic [1:0] {
        BOOK_HOLD = 2'd0,
        BOOK_INS  = 2'd1,
        BOOK_POP  = 2'd2,
        BOOK_DEC  = 2'd3
    } t_book_op;

    // Command from the controller to one side.
    typedef struct packed {
        t_book_op         op;
        t_entry           ent;
        logic [QTY_W-1:0] dec;
    } t_side_cmd;

    // View of the two best entries of a side.
    typedef struct packed {
        t_entry head;
        logic   head_valid;
        t_entry second;
        logic   second_valid;
        logic   full;
    } t_side_stat;

    // True if x ranks strictly ahead of y on the given side.
    function automatic logic ahead(input t_entry x, input t_entry y, input logic sell);
        logic better;
        better = sell ? (x.price < y.price) : (x.price > y.price);
        return !y.mkt && (x.mkt || better);
    endfunction

    // True if a buy and a sell can trade.
    function automatic logic crosses(input t_entry b, input t_entry s);
        return b.mkt || s.mkt || (b.price >= s.price);
    endfunction

endpackage

FILE: rtl/core/lobm_cell.sv
// One slot of a sorted book side; shifts entries with its neighbors.
module lobm_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_is_sell,
    input  lobm_pkg::t_book_op i_op,
    input  lobm_pkg::t_entry   i_new,
    input  logic [19:0]        i_dec,
    input  logic               i_prev_ins,
    input  lobm_pkg::t_entry   i_prev_ent,
    input  logic               i_prev_valid,
    input  lobm_pkg::t_entry   i_next_ent,
    input  logic               i_next_valid,
    output lobm_pkg::t_entry   o_ent,
    output logic               o_valid,
    output logic               o_ins
);
    import lobm_pkg::*;

    t_entry r_ent;
    logic   r_valid;

    // The new entry belongs at or above this slot.
    assign o_ins   = !r_valid || ahead(i_new, r_ent, i_is_sell);
    assign o_ent   = r_ent;
    assign o_valid = r_valid;

    // Valid bit of the slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            unique case (i_op)
                BOOK_INS: begin
                    if (o_ins && !i_prev_ins) begin
                        r_valid <= 1'b1;
                    end else if (o_ins) begin
                        r_valid <= i_prev_valid;
                    end
                end
                BOOK_POP: r_valid <= i_next_valid;
                default:  r_valid <= r_valid;
            endcase
        end
    end

    // Entry payload of the slot.
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            BOOK_INS: begin
                if (o_ins && !i_prev_ins) begin
                    r_ent <= i_new;
                end else if (o_ins) begin
                    r_ent <= i_prev_ent;
                end
            end
            BOOK_POP: r_ent <= i_next_ent;
            BOOK_DEC: r_ent.qty <= r_ent.qty - i_dec;
            default:  r_ent <= r_ent;
        endcase
    end

endmodule

FILE: rtl/core/lobm_side.sv
// One side of the book: a row of slots kept in rank order.
module lobm_side (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_is_sell,
    input  lobm_pkg::t_side_cmd  i_cmd,
    output lobm_pkg::t_side_stat o_stat
);
    import lobm_pkg::*;

    t_entry   w_ent   [BOOK_DEPTH];
    logic     w_valid [BOOK_DEPTH];
    logic     w_ins   [BOOK_DEPTH];
    t_book_op w_op    [BOOK_DEPTH];

    genvar k;
    generate
        for (k = 0; k < BOOK_DEPTH; k++) begin : g_cell
            t_entry prev_ent;
            logic   prev_valid;
            logic   prev_ins;
            t_entry next_ent;
            logic   next_valid;

            // Only the head slot takes a quantity decrement.
            if (k == 0) begin : g_head
                assign w_op[k]    = i_cmd.op;
                assign prev_ent   = i_cmd.ent;
                assign prev_valid = 1'b0;
                assign prev_ins   = 1'b0;
            end else begin : g_body
                assign w_op[k]    = (i_cmd.op == BOOK_DEC) ? BOOK_HOLD : i_cmd.op;
                assign prev_ent   = w_ent[k-1];
                assign prev_valid = w_valid[k-1];
                assign prev_ins   = w_ins[k-1];
            end

            if (k == BOOK_DEPTH - 1) begin : g_tail
                assign next_ent   = w_ent[k];
                assign next_valid = 1'b0;
            end else begin : g_mid
                assign next_ent   = w_ent[k+1];
                assign next_valid = w_valid[k+1];
            end

            lobm_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_is_sell    (i_is_sell),
                .i_op         (w_op[k]),
                .i_new        (i_cmd.ent),
                .i_dec        (i_cmd.dec),
                .i_prev_ins   (prev_ins),
                .i_prev_ent   (prev_ent),
                .i_prev_valid (prev_valid),
                .i_next_ent   (next_ent),
                .i_next_valid (next_valid),
                .o_ent        (w_ent[k]),
                .o_valid      (w_valid[k]),
                .o_ins        (w_ins[k])
            );
        end
    endgenerate

    // Status seen by the controller.
    assign o_stat.head         = w_ent[0];
    assign o_stat.head_valid   = w_valid[0];
    assign o_stat.second       = w_ent[1];
    assign o_stat.second_valid = w_valid[1];
    assign o_stat.full         = w_valid[BOOK_DEPTH-1];

endmodule

FILE: rtl/core/limit_order_book_matcher.sv
// Top level: order book matcher with controller and result register.
// An add is inserted into its side in the cycle it is accepted. Matching
// then produces one trade word per cycle while the output is not stalled,
// and each trade pops the exhausted head of either side. The next input can
// be taken once the controller is idle again, after the last result has
// entered the output register or after the check that finds no crossing
// pair. A flush reports each resting order, buy side first. A rejected add,
// a zero-quantity add or a flush of an empty book leaves the controller
// idle. A result that waits on a stalled output holds the controller. Each
// side is a row of BOOK_DEPTH slots that insert by shifting down and pop by
// shifting up.
module limit_order_book_matcher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [23:0] i_cfg_wdata,    // opening_price
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // side[0], is_market[1], order_id[17:2], quantity[37:18], limit_price[61:38], zero[63:62]
    input  logic [63:0] s_axis_tdata,
    input  logic        s_axis_tuser,   // opcode[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // buyer_or_order[15:0], seller_id[31:16], report_side[32], shares[52:33],
    // trade_price[76:53], zero[79:77]
    output logic [79:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // kind[1:0]
    output logic        m_axis_tlast
);
    import lobm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_FLUSH
    } t_state;

    t_state               r_state;
    logic [PRICE_W-1:0]   r_open;
    logic [PRICE_W-1:0]   r_last_px;
    logic                 r_traded;
    logic                 r_in_side;
    logic                 r_ovalid;
    logic [OUT_DATA_W-1:0] r_odata;
    t_kind                r_okind;
    logic                 r_olast;

    t_side_cmd  w_bcmd, w_scmd;
    t_side_stat w_bst, w_sst;

    // Input word fields.
    logic               in_side, in_mkt;
    logic [ID_W-1:0]    in_id;
    logic [QTY_W-1:0]   in_qty;
    logic [PRICE_W-1:0] in_px;
    t_entry             in_ent;
    logic               in_acc, out_free, out_load;

    assign in_side = s_axis_tdata[0];
    assign in_mkt  = s_axis_tdata[1];
    assign in_id   = s_axis_tdata[17:2];
    assign in_qty  = s_axis_tdata[37:18];
    assign in_px   = s_axis_tdata[61:38];

    assign in_ent.id    = in_id;
    assign in_ent.qty   = in_qty;
    assign in_ent.price = in_mkt ? '0 : in_px;
    assign in_ent.mkt   = in_mkt;

    assign out_free      = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Book sides.
    lobm_side u_buy (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_is_sell (SIDE_BUY),
        .i_cmd     (w_bcmd),
        .o_stat    (w_bst)
    );

    lobm_side u_sell (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_is_sell (SIDE_SELL),
        .i_cmd     (w_scmd),
        .o_stat    (w_sst)
    );

    // Trade evaluation on the two heads.
    t_entry             b, s, nb, ns;
    logic               cross_now, nbv, nsv, last_trade;
    logic [QTY_W-1:0]   tq, b_rem, s_rem;
    logic [PRICE_W-1:0] tpx;

    assign b = w_bst.head;
    assign s = w_sst.head;
    assign cross_now = w_bst.head_valid && w_sst.head_valid && crosses(b, s);
    assign tq    = (b.qty < s.qty) ? b.qty : s.qty;
    assign b_rem = b.qty - tq;
    assign s_rem = s.qty - tq;

    always_comb begin
        priority if (b.mkt && s.mkt) begin
            tpx = r_traded ? r_last_px : r_open;
        end else if (b.mkt) begin
            tpx = s.price;
        end else if (s.mkt) begin
            tpx = b.price;
        end else begin
            tpx = r_in_side ? b.price : s.price;
        end
    end

    // Heads after this trade, to see whether another trade follows.
    always_comb begin
        nb     = b;
        nb.qty = b_rem;
        nbv    = 1'b1;
        if (b_rem == '0) begin
            nb  = w_bst.second;
            nbv = w_bst.second_valid;
        end
        ns     = s;
        ns.qty = s_rem;
        nsv    = 1'b1;
        if (s_rem == '0) begin
            ns  = w_sst.second;
            nsv = w_sst.second_valid;
        end
    end
    assign last_trade = !(nbv && nsv && crosses(nb, ns));

    // A result word enters the output register in this cycle.
    assign out_load = (r_state == ST_IDLE && in_acc && s_axis_tuser == OP_ADD &&
                       in_qty != '0 &&
                       ((in_side == SIDE_BUY && w_bst.full) ||
                        (in_side == SIDE_SELL && w_sst.full))) ||
                      (r_state == ST_MATCH && cross_now && out_free) ||
                      (r_state == ST_FLUSH && out_free);

    // Side commands.
    always_comb begin
        w_bcmd.op  = BOOK_HOLD;
        w_bcmd.ent = in_ent;
        w_bcmd.dec = tq;
        w_scmd.op  = BOOK_HOLD;
        w_scmd.ent = in_ent;
        w_scmd.dec = tq;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && s_axis_tuser == OP_ADD && in_qty != '0) begin
                    if (in_side == SIDE_BUY && !w_bst.full) begin
                        w_bcmd.op = BOOK_INS;
                    end
                    if (in_side == SIDE_SELL && !w_sst.full) begin
                        w_scmd.op = BOOK_INS;
                    end
                end
            end
            ST_MATCH: begin
                if (out_free && cross_now) begin
                    w_bcmd.op = (b_rem == '0) ? BOOK_POP : BOOK_DEC;
                    w_scmd.op = (s_rem == '0) ? BOOK_POP : BOOK_DEC;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    if (w_bst.head_valid) begin
                        w_bcmd.op = BOOK_POP;
                    end else begin
                        w_scmd.op = BOOK_POP;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Controller state, price history and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_open    <= '0;
            r_last_px <= '0;
            r_traded  <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_open <= i_cfg_wdata;
            end
            r_ovalid <= out_load || (r_ovalid && !m_axis_tready);
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_in_side <= in_side;
                        if (s_axis_tuser == OP_FLUSH) begin
                            if (w_bst.head_valid || w_sst.head_valid) begin
                                r_state <= ST_FLUSH;
                            end
                        end else if (in_qty != '0) begin
                            if ((in_side == SIDE_BUY && w_bst.full) ||
                                (in_side == SIDE_SELL && w_sst.full)) begin
                                r_okind  <= KIND_REJECT;
                                r_olast  <= 1'b1;
                                r_odata  <= {3'b000, {PRICE_W{1'b0}}, in_qty, in_side,
                                             {ID_W{1'b0}}, in_id};
                            end else begin
                                r_state <= ST_MATCH;
                            end
                        end
                    end
                end
                ST_MATCH: begin
                    if (!cross_now) begin
                        r_state <= ST_IDLE;
                    end else if (out_free) begin
                        r_okind   <= KIND_TRADE;
                        r_olast   <= last_trade;
                        r_odata   <= {3'b000, tpx, tq, 1'b0, s.id, b.id};
                        r_last_px <= tpx;
                        r_traded  <= 1'b1;
                        if (last_trade) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (out_free) begin
                        r_okind  <= KIND_UNEXEC;
                        if (w_bst.head_valid) begin
                            r_olast <= !w_bst.second_valid && !w_sst.head_valid;
                            r_odata <= {3'b000, {PRICE_W{1'b0}}, b.qty, SIDE_BUY,
                                        {ID_W{1'b0}}, b.id};
                            if (!w_bst.second_valid && !w_sst.head_valid) begin
                                r_state <= ST_IDLE;
                            end
                        end else begin
                            r_olast <= !w_sst.second_valid;
                            r_odata <= {3'b000, {PRICE_W{1'b0}}, s.qty, SIDE_SELL,
                                        {ID_W{1'b0}}, s.id};
                            if (!w_sst.second_valid) begin
                                r_state <= ST_IDLE;
                            end
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;

    // A book at rest never holds a crossing pair.
    a_rest_uncrossed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && $past(r_state) != ST_IDLE && i_rst_n && $past(i_rst_n))
        |-> !cross_now)
        else $error("book left crossed after matching");

    // A flush empties both sides.
    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == ST_FLUSH && r_state == ST_IDLE && $past(i_rst_n))
        |-> (!w_bst.head_valid && !w_sst.head_valid))
        else $error("flush left orders in the book");

    // A rejected add leaves the heads unchanged.
    a_reject_keeps_book: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && s_axis_tuser == OP_ADD && in_qty != '0 &&
         ((in_side == SIDE_BUY && w_bst.full) || (in_side == SIDE_SELL && w_sst.full)))
        |=> ($stable(w_bst.head_valid) && $stable(w_sst.head_valid) &&
             (!w_bst.head_valid || $stable(w_bst.head)) &&
             (!w_sst.head_valid || $stable(w_sst.head)) && r_state == ST_IDLE))
        else $error("rejected add changed the book");

endmodule

FILE: bench/tb.sv
// Self-checking testbench for the limit order book matcher.
module tb;
    import lobm_pkg::*;

    localparam int RUN_LIMIT = 1000000;
    localparam int SETTLE    = 40;

    // One expected result word.
    typedef struct {
        t_kind              kind;
        logic [ID_W-1:0]    buyer_or_order;
        logic [ID_W-1:0]    seller_id;
        logic               report_side;
        logic [QTY_W-1:0]   shares;
        logic [PRICE_W-1:0] trade_price;
        logic               last;
    } t_fill;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [23:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // Shadow copy of the book and pricing state.
    t_entry             bids [BOOK_DEPTH];
    t_entry             asks [BOOK_DEPTH];
    int                 bid_cnt;
    int                 ask_cnt;
    logic [PRICE_W-1:0] last_px;
    logic               traded;
    logic [PRICE_W-1:0] open_px;

    t_fill pending_fills[$];
    int    errors;
    int    cycles;
    bit    calm;

    limit_order_book_matcher dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Fails the run if it never reaches its end.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT) begin
            $display("limit_order_book_matcher regression: fail");
            $finish;
        end
    end

    // Random gap length: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(30, 5);
    endfunction

    // Output stall generator.
    initial begin
        int g;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready = 1'b1;
            g = pick_gap();
            if (g > 0) begin
                @(negedge i_clk);
                m_axis_tready = 1'b0;
                repeat (g - 1) @(negedge i_clk);
            end
        end
    end

    // Compares each accepted result word with the oldest expectation.
    always @(posedge i_clk) begin
        t_fill e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_fills.size() == 0) begin
                $error("unexpected result word %h kind %0d", m_axis_tdata, m_axis_tuser);
                errors++;
            end else begin
                e = pending_fills.pop_front();
                if (m_axis_tuser != e.kind) begin
                    $error("kind: expected %0d, got %0d", e.kind, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata[15:0] != e.buyer_or_order) begin
                    $error("buyer_or_order: expected %0d, got %0d",
                           e.buyer_or_order, m_axis_tdata[15:0]);
                    errors++;
                end
                if (m_axis_tdata[31:16] != e.seller_id) begin
                    $error("seller_id: expected %0d, got %0d", e.seller_id, m_axis_tdata[31:16]);
                    errors++;
                end
                if (m_axis_tdata[32] != e.report_side) begin
                    $error("report_side: expected %0d, got %0d", e.report_side, m_axis_tdata[32]);
                    errors++;
                end
                if (m_axis_tdata[52:33] != e.shares) begin
                    $error("shares: expected %0d, got %0d", e.shares, m_axis_tdata[52:33]);
                    errors++;
                end
                if (m_axis_tdata[76:53] != e.trade_price) begin
                    $error("trade_price: expected %0d, got %0d",
                           e.trade_price, m_axis_tdata[76:53]);
                    errors++;
                end
                if (m_axis_tdata[79:77] != 3'b000) begin
                    $error("pad: expected 0, got %0d", m_axis_tdata[79:77]);
                    errors++;
                end
                if (m_axis_tlast != e.last) begin
                    $error("last: expected %0d, got %0d", e.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    function automatic void push_fill(t_kind k, logic [15:0] a, logic [15:0] b, logic sd,
                                      logic [19:0] q, logic [23:0] px);
        t_fill f;
        f.kind = k;
        f.buyer_or_order = a;
        f.seller_id = b;
        f.report_side = sd;
        f.shares = q;
        f.trade_price = px;
        f.last = 1'b0;
        pending_fills.insert(pending_fills.size(), f);
    endfunction

    // True if x outranks y: market first, then best price, ties keep arrival order.
    function automatic bit outranks(t_entry x, t_entry y, logic sell);
        if (y.mkt) return 0;
        if (x.mkt) return 1;
        return sell ? (x.price < y.price) : (x.price > y.price);
    endfunction

    // Applies one accepted word to the shadow book and queues its results.
    function automatic void match_order(logic op, logic sd, logic mkt, logic [15:0] id,
                                        logic [19:0] qty, logic [23:0] lim);
        int n0;
        int pos;
        int made;
        t_entry e;
        t_entry b;
        t_entry s;
        logic [23:0] px;
        logic [19:0] q;
        n0 = pending_fills.size();
        made = 0;
        if (op == OP_FLUSH) begin
            for (int i = 0; i < bid_cnt; i++)
                push_fill(KIND_UNEXEC, bids[i].id, 16'd0, SIDE_BUY, bids[i].qty, 24'd0);
            for (int i = 0; i < ask_cnt; i++)
                push_fill(KIND_UNEXEC, asks[i].id, 16'd0, SIDE_SELL, asks[i].qty, 24'd0);
            bid_cnt = 0;
            ask_cnt = 0;
        end else if (qty != 0) begin
            if ((sd == SIDE_SELL ? ask_cnt : bid_cnt) >= BOOK_DEPTH) begin
                push_fill(KIND_REJECT, id, 16'd0, sd, qty, 24'd0);
            end else begin
                e.id = id;
                e.qty = qty;
                e.price = mkt ? 24'd0 : lim;
                e.mkt = mkt;
                if (sd == SIDE_SELL) begin
                    pos = 0;
                    while (pos < ask_cnt && !outranks(e, asks[pos], 1'b1)) pos++;
                    for (int i = ask_cnt; i > pos; i--) asks[i] = asks[i-1];
                    asks[pos] = e;
                    ask_cnt++;
                end else begin
                    pos = 0;
                    while (pos < bid_cnt && !outranks(e, bids[pos], 1'b0)) pos++;
                    for (int i = bid_cnt; i > pos; i--) bids[i] = bids[i-1];
                    bids[pos] = e;
                    bid_cnt++;
                end
                // Trade the two heads while they cross.
                while (bid_cnt > 0 && ask_cnt > 0 && made < 64) begin
                    b = bids[0];
                    s = asks[0];
                    if (!(b.mkt || s.mkt || b.price >= s.price)) break;
                    if (b.mkt && s.mkt) px = traded ? last_px : open_px;
                    else if (b.mkt) px = s.price;
                    else if (s.mkt) px = b.price;
                    else px = (sd == SIDE_SELL) ? b.price : s.price;
                    q = (b.qty < s.qty) ? b.qty : s.qty;
                    push_fill(KIND_TRADE, b.id, s.id, 1'b0, q, px);
                    made++;
                    last_px = px;
                    traded = 1'b1;
                    bids[0].qty -= q;
                    asks[0].qty -= q;
                    if (bids[0].qty == 0) begin
                        for (int i = 0; i < bid_cnt - 1; i++) bids[i] = bids[i+1];
                        bid_cnt--;
                    end
                    if (asks[0].qty == 0) begin
                        for (int i = 0; i < ask_cnt - 1; i++) asks[i] = asks[i+1];
                        ask_cnt--;
                    end
                end
            end
        end
        if (pending_fills.size() > n0) pending_fills[pending_fills.size() - 1].last = 1'b1;
    endfunction

    // Sends one word after a random gap and predicts it once accepted.
    task automatic send_order(logic op, logic sd, logic mkt, logic [15:0] id,
                              logic [19:0] qty, logic [23:0] lim);
        int g;
        g = pick_gap();
        if (g > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (g - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser = op;
        s_axis_tdata = {2'b00, lim, qty, id, mkt, sd};
        do @(posedge i_clk); while (!s_axis_tready);
        match_order(op, sd, mkt, id, qty, lim);
    endtask

    // Waits for every expected word, then for any trailing no-result work.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_fills.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Writes the opening price while the block is idle.
    task automatic set_opening(logic [23:0] px);
        drain();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = px;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        open_px = px;
    endtask

    // Field extremes, every operation and each corner case by hand.
    task automatic test_directed();
        set_opening(24'hFFFFFF);
        // Market against market before any trade uses the opening price.
        send_order(OP_ADD, SIDE_BUY, 1'b1, 16'h0001, 20'd10, 24'hABCDEF);
        send_order(OP_ADD, SIDE_SELL, 1'b1, 16'h0002, 20'd4, 24'd0);
        // Empty sell side after this; flush reports the buy remainder.
        send_order(OP_FLUSH, SIDE_SELL, 1'b1, 16'hFFFF, 20'hFFFFF, 24'hFFFFFF);
        send_order(OP_FLUSH, SIDE_BUY, 1'b0, 16'd0, 20'd0, 24'd0);
        // Zero quantity is ignored.
        send_order(OP_ADD, SIDE_BUY, 1'b0, 16'h1234, 20'd0, 24'd50);
        // Equal prices keep arrival order; a market order jumps the queue.
        send_order(OP_ADD, SIDE_SELL, 1'b0, 16'h0010, 20'd5, 24'd100);
        send_order(OP_ADD, SIDE_SELL, 1'b0, 16'h0011, 20'd5, 24'd100);
        send_order(OP_ADD, SIDE_SELL, 1'b0, 16'h0012, 20'd5, 24'd90);
        send_order(OP_ADD, SIDE_BUY, 1'b0, 16'h0020, 20'd7, 24'd80);
        send_order(OP_ADD, SIDE_BUY, 1'b0, 16'h0021, 20'd3, 24'd80);
        send_order(OP_ADD, SIDE_BUY, 1'b1, 16'h0022, 20'd12, 24'd1);
        send_order(OP_ADD, SIDE_BUY, 1'b0, 16'hFFFF, 20'hFFFFF, 24'hFFFFFF);
        // Sweep with a sell market order; later market pair uses last price.
        send_order(OP_ADD, SIDE_SELL, 1'b1, 16'h0030, 20'd30, 24'd0);
        send_order(OP_ADD, SIDE_SELL, 1'b0, 16'h0031, 20'hFFFFF, 24'd0);
        send_order(OP_ADD, SIDE_BUY, 1'b1, 16'h0040, 20'd2, 24'd0);
        send_order(OP_ADD, SIDE_SELL, 1'b1, 16'h0041, 20'd2, 24'd0);
        send_order(OP_FLUSH, SIDE_BUY, 1'b0, 16'd0, 20'd1, 24'd0);
        // Flush keeps the last price.
        send_order(OP_ADD, SIDE_SELL, 1'b1, 16'h0050, 20'd1, 24'd0);
        send_order(OP_ADD, SIDE_BUY, 1'b1, 16'h0051, 20'd1, 24'd0);
        drain();
    endtask

    // Fills both sides, rejects one more on each, then flushes the lot.
    task automatic test_full_book();
        set_opening(24'd0);
        calm = 1'b1;
        for (int i = 0; i < BOOK_DEPTH; i++)
            send_order(OP_ADD, SIDE_BUY, 1'b0, 16'(16'h0100 + i), 20'(i + 1),
                       24'(100 + (i % 3)));
        send_order(OP_ADD, SIDE_BUY, 1'b1, 16'h0200, 20'd9, 24'd0);
        calm = 1'b0;
        for (int i = 0; i < BOOK_DEPTH; i++)
            send_order(OP_ADD, SIDE_SELL, 1'b0, 16'(16'h0300 + i), 20'(i + 1),
                       24'(200 - (i % 4)));
        send_order(OP_ADD, SIDE_SELL, 1'b0, 16'h0400, 20'd9, 24'd1);
        send_order(OP_FLUSH, SIDE_BUY, 1'b0, 16'd0, 20'd0, 24'd0);
        drain();
    endtask

    // Random order flow around a fixed random mid price, with some noise.
    task automatic test_random_flow(int count, logic [23:0] opening);
        int r;
        logic [23:0] mid;
        logic [19:0] q;
        logic [23:0] px;
        set_opening(opening);
        mid = 24'($urandom_range(1000, 20));
        for (int i = 0; i < count; i++) begin
            calm = (i % 40) < 8;
            r = $urandom_range(99);
            if (r < 4) begin
                send_order(OP_FLUSH, 1'($urandom), 1'($urandom), 16'($urandom),
                           20'($urandom), 24'($urandom));
            end else begin
                q = (r < 10) ? 20'($urandom) : 20'($urandom_range(20, 1));
                if (r == 99) q = 20'd0;
                px = (r > 92) ? 24'($urandom) : 24'(mid + $urandom_range(10) - 5);
                send_order(OP_ADD, 1'($urandom), ($urandom_range(9) == 0),
                           16'($urandom), q, px);
            end
        end
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        errors = 0;
        cycles = 0;
        calm = 1'b0;
        bid_cnt = 0;
        ask_cnt = 0;
        last_px = '0;
        traded = 1'b0;
        open_px = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_full_book();
        test_random_flow(15, 24'd0);
        test_random_flow(15, 24'hFFFFFF);
        test_random_flow(15, 24'($urandom));

        if (errors == 0) begin
            $display("limit_order_book_matcher regression: pass");
        end else begin
            $display("limit_order_book_matcher regression: fail");
        end
        $finish;
    end

endmodule
